/* src/osrs_pkg.sv */
// ----------------------------------------------------------------------------
// osrs_pkg: ordered set with rank and select, shared definitions
// Field widths, request codes, controller states and the result bundle.
// ----------------------------------------------------------------------------
package osrs_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int VALUE_W      = 17;
	localparam int POS_W        = 10;
	localparam int ANSWER_W     = 18;

	localparam logic signed [ANSWER_W-1:0] ANSWER_NONE = -18'sd1;

	typedef enum logic [1:0] {
		MODE_ADD     = 2'd0,
		MODE_REMOVE  = 2'd1,
		MODE_FIND    = 2'd2,
		MODE_FINDPOS = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SCMP,
		ST_SHIFT,
		ST_DRAIN,
		ST_PUT,
		ST_FETCH,
		ST_RESULT
	} state_t;

	// result offered by the controller to the output register
	typedef struct packed {
		logic                       valid;
		logic signed [ANSWER_W-1:0] answer;
	} res_t;

endpackage

/* src/osrs_req_if.sv */
// ----------------------------------------------------------------------------
// osrs_req_if: request channel
// One beat carries an operation code, a value and a position.
// ----------------------------------------------------------------------------
interface osrs_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic [osrs_pkg::VALUE_W-1:0]  value;
	logic [osrs_pkg::POS_W-1:0]    position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

/* src/osrs_rsp_if.sv */
// ----------------------------------------------------------------------------
// osrs_rsp_if: response channel
// One beat carries the signed answer of a find or findpos request.
// ----------------------------------------------------------------------------
interface osrs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [osrs_pkg::ANSWER_W-1:0] answer;

	modport source (output valid, output answer, input ready);
	modport sink   (input valid, input answer, output ready);
endinterface

/* src/osrs_ram.sv */
// ----------------------------------------------------------------------------
// osrs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module osrs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/osrs_ctrl.sv */
// ----------------------------------------------------------------------------
// osrs_ctrl: sequencer for the sorted store
// Binary search over the RAM, then shift entries up or down one per cycle
// for add and remove, or read one entry for find.
// ----------------------------------------------------------------------------
module osrs_ctrl #(
	parameter int CAPACITY = osrs_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	osrs_req_if.sink                      req,
	output osrs_pkg::res_t                res,
	input  logic                          res_ready,
	output logic                          ram_wr_en,
	output logic [$clog2(CAPACITY)-1:0]   ram_wr_addr,
	output logic [osrs_pkg::VALUE_W-1:0]  ram_wr_data,
	output logic                          ram_rd_en,
	output logic [$clog2(CAPACITY)-1:0]   ram_rd_addr,
	input  logic [osrs_pkg::VALUE_W-1:0]  ram_rd_data
);
	import osrs_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                     state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	mode_t                      op_q, op_d;
	logic [VALUE_W-1:0]         v_q, v_d;
	logic [CW-1:0]              lo_q, lo_d;
	logic [CW-1:0]              hi_q, hi_d;
	logic [CW-1:0]              mid_q, mid_d;
	logic                       hit_q, hit_d;
	logic [IW-1:0]              cur_q, cur_d;
	logic signed [ANSWER_W-1:0] res_q, res_d;
	logic                       pend_s1;
	logic [IW-1:0]              wr_addr_s1;
	logic [IW-1:0]              shift_wr_addr;
	logic [CW-1:0]              mid;

	// midpoint of the open search range
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// shift target: one slot up for add, one slot down for remove
	assign shift_wr_addr = (op_q == MODE_ADD) ? (cur_q + IW'(1)) : (cur_q - IW'(1));

	// next state, datapath loads and memory ports
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		op_d        = op_q;
		v_d         = v_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		hit_d       = hit_q;
		cur_d       = cur_q;
		res_d       = res_q;
		req.ready   = (state_q == ST_IDLE);
		res.valid   = 1'b0;
		res.answer  = res_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = mid[IW-1:0];
		ram_wr_en   = pend_s1;
		ram_wr_addr = wr_addr_s1;
		ram_wr_data = ram_rd_data;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_d  = mode_t'(req.mode);
					v_d   = req.value;
					lo_d  = '0;
					hi_d  = count_q;
					hit_d = 1'b0;
					if (mode_t'(req.mode) == MODE_FIND) begin
						if (32'(req.position) < 32'(count_q)) begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = IW'(req.position);
							state_d     = ST_FETCH;
						end else begin
							res_d   = ANSWER_NONE;
							state_d = ST_RESULT;
						end
					end else begin
						state_d = ST_SRCH;
					end
				end
			end
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					// probe the midpoint
					ram_rd_en = 1'b1;
					mid_d     = mid;
					state_d   = ST_SCMP;
				end else begin
					case (op_q)
						MODE_FINDPOS: begin
							res_d   = $signed(ANSWER_W'(lo_q));
							state_d = ST_RESULT;
						end
						MODE_ADD: begin
							if (hit_q || count_q == CW'(CAPACITY)) begin
								state_d = ST_IDLE;
							end else if (lo_q == count_q) begin
								state_d = ST_PUT;
							end else begin
								cur_d   = IW'(count_q - CW'(1));
								state_d = ST_SHIFT;
							end
						end
						MODE_REMOVE: begin
							if (!hit_q) begin
								state_d = ST_IDLE;
							end else if (lo_q + CW'(1) == count_q) begin
								count_d = count_q - CW'(1);
								state_d = ST_IDLE;
							end else begin
								cur_d   = IW'(lo_q + CW'(1));
								state_d = ST_SHIFT;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCMP: begin
				// narrow the range toward the first element not below the key
				if (ram_rd_data < v_q) begin
					lo_d = mid_q + CW'(1);
				end else begin
					hi_d  = mid_q;
					hit_d = (ram_rd_data == v_q);
				end
				state_d = ST_SRCH;
			end
			ST_SHIFT: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = cur_q;
				if (op_q == MODE_ADD) begin
					if (CW'(cur_q) == lo_q) begin
						state_d = ST_DRAIN;
					end else begin
						cur_d = cur_q - IW'(1);
					end
				end else begin
					if (CW'(cur_q) == count_q - CW'(1)) begin
						state_d = ST_DRAIN;
					end else begin
						cur_d = cur_q + IW'(1);
					end
				end
			end
			ST_DRAIN: begin
				// last moved entry is written this cycle
				if (op_q == MODE_ADD) begin
					state_d = ST_PUT;
				end else begin
					count_d = count_q - CW'(1);
					state_d = ST_IDLE;
				end
			end
			ST_PUT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = lo_q[IW-1:0];
				ram_wr_data = v_q;
				count_d     = count_q + CW'(1);
				state_d     = ST_IDLE;
			end
			ST_FETCH: begin
				res_d   = $signed(ANSWER_W'(ram_rd_data));
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= (state_q == ST_SHIFT);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		v_q        <= v_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		mid_q      <= mid_d;
		hit_q      <= hit_d;
		cur_q      <= cur_d;
		res_q      <= res_d;
		wr_addr_s1 <= shift_wr_addr;
	end

`ifndef SYNTH
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("element count moved by more than one");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q && hi_q <= count_q))
		else $error("search range outside the set");

	a_shift_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (CW'(cur_q) < count_q))
		else $error("shift cursor past the last element");

	a_pend_write: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SHIFT || state_q == ST_DRAIN))
		else $error("moved entry written outside a shift");
`endif

endmodule

/* src/ordered_set_rank_select_core.sv */
// ----------------------------------------------------------------------------
// ordered_set_rank_select_core: ordered set with rank and select
// Keeps distinct values in ascending order in a RAM; add, remove, find by
// position and rank of a value.
//
//   channel  direction  beat contents
//   req      in         mode, value, position
//   rsp      out        answer (find and findpos only)
//
// Each search probe reads the midpoint in ST_SRCH and compares it in ST_SCMP.
// Add and remove then move one entry per cycle through the RAM's read port
// and write port. Find reads the entry at its position, if that position is held.
// Reset clears the element count; the RAM contents need no clearing.
// A response waits in an output register; a new request is taken while it
// waits, and only a second response stalls behind it.
// ----------------------------------------------------------------------------
module ordered_set_rank_select_core #(
	parameter int CAPACITY = osrs_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	osrs_req_if.sink   req,
	osrs_rsp_if.source rsp
);
	import osrs_pkg::*;

	localparam int IW = $clog2(CAPACITY);

	res_t                       res;
	logic                       res_ready;
	logic                       out_valid_q;
	logic signed [ANSWER_W-1:0] out_answer_q;
	logic                       ram_wr_en;
	logic [IW-1:0]              ram_wr_addr;
	logic [VALUE_W-1:0]         ram_wr_data;
	logic                       ram_rd_en;
	logic [IW-1:0]              ram_rd_addr;
	logic [VALUE_W-1:0]         ram_rd_data;

	osrs_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.res         (res),
		.res_ready   (res_ready),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	osrs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// output register is free when empty or draining this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	// hold the response beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_answer_q <= res.answer;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.answer = out_answer_q;

endmodule

/* test/ordered_set_rank_select_core_tb.sv */
// ----------------------------------------------------------------------------
// ordered_set_rank_select_core_tb: self-checking bench for the ordered set
// Drives add, remove, find and findpos requests under random handshake gaps.
// A mirror of the sorted set predicts each answer, and every response beat is
// compared in order. A directed opening is followed by an ascending fill, a
// drain back to empty, and a random phase over a small live set.
// ----------------------------------------------------------------------------
module ordered_set_rank_select_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import osrs_pkg::*;

	localparam int STALL_LIMIT   = 12000;
	localparam int SETTLE_CYCLES = 1200;
	localparam int FILL_ITEMS    = 128;
	localparam int RANDOM_ITEMS  = 278;
	localparam int MAX_PRINTS    = 40;

	// Sorted mirror of the set and the answers it still owes
	class rank_select_mirror;
		logic [VALUE_W-1:0]         elems [CAPACITY_DEF];
		int unsigned                n_elems;
		logic signed [ANSWER_W-1:0] answers_due [$];
		int                         mismatches;

		function new();
			n_elems    = 0;
			mismatches = 0;
		endfunction

		// count of elements smaller than v
		function int unsigned rank_of(logic [VALUE_W-1:0] v);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = n_elems;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (elems[mid] < v) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			return lo;
		endfunction

		function bit holds(logic [VALUE_W-1:0] v);
			int unsigned at;
			at = rank_of(v);
			return at < n_elems && elems[at] == v;
		endfunction

		// apply one accepted request beat
		function void take_request(mode_t m, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
			int unsigned at;
			int unsigned i;
			logic signed [ANSWER_W-1:0] ans;
			at = rank_of(v);
			case (m)
				MODE_ADD: begin
					// drop duplicates and adds into a full store
					if (!(at < n_elems && elems[at] == v) && n_elems < CAPACITY_DEF) begin
						for (i = n_elems; i > at; i--)
							elems[i] = elems[i-1];
						elems[at] = v;
						n_elems++;
					end
				end
				MODE_REMOVE: begin
					if (at < n_elems && elems[at] == v) begin
						for (i = at; i + 1 < n_elems; i++)
							elems[i] = elems[i+1];
						n_elems--;
					end
				end
				MODE_FIND: begin
					if (p < n_elems) begin
						ans = $signed({1'b0, elems[p]});
					end else begin
						ans = ANSWER_NONE;
					end
					answers_due.push_back(ans);
				end
				default: begin
					ans = $signed(ANSWER_W'(at));
					answers_due.push_back(ans);
				end
			endcase
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		// compare one response beat with the oldest answer due
		task match_answer(logic signed [ANSWER_W-1:0] got);
			logic signed [ANSWER_W-1:0] want;
			if (answers_due.size() == 0) begin
				report($sformatf("answer %0d arrived with none due", got));
			end else begin
				want = answers_due.pop_front();
				if (got !== want)
					report($sformatf("answer %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   no_gaps;
	int   stalled_cycles;

	osrs_req_if req_ch ();
	osrs_rsp_if rsp_ch ();

	rank_select_mirror mirror = new();

	ordered_set_rank_select_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Track accepted beats on both channels and guard against a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				mirror.take_request(mode_t'(req_ch.mode), req_ch.value, req_ch.position);
			if (rsp_ch.valid && rsp_ch.ready)
				mirror.match_answer(rsp_ch.answer);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stalled_cycles <= 0;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Toggle response ready: mostly short stalls, a few long, some long open runs
	initial begin
		int unsigned open_len;
		int unsigned hold_len;
		int unsigned r;
		rsp_ch.ready <= 1'b0;
		repeat (10) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				open_len = $urandom_range(1, 8);
			end else if (r < 90) begin
				open_len = $urandom_range(9, 40);
			end else begin
				open_len = $urandom_range(100, 400);
			end
			rsp_ch.ready <= 1'b1;
			repeat (open_len) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				hold_len = $urandom_range(1, 3);
			end else if (r < 95) begin
				hold_len = $urandom_range(4, 15);
			end else begin
				hold_len = $urandom_range(30, 100);
			end
			rsp_ch.ready <= 1'b0;
			repeat (hold_len) @(posedge clk);
		end
	end

	function automatic logic [VALUE_W-1:0] any_value();
		return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
	endfunction

	function automatic logic [POS_W-1:0] any_position();
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	// Offer one request beat and hold it until accepted
	task automatic send_req(mode_t m, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
		req_ch.mode     <= m;
		req_ch.value    <= v;
		req_ch.position <= p;
		req_ch.valid    <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid for a random number of cycles
	task automatic idle_sender();
		int unsigned n;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) begin
			n = 0;
		end else if (r < 85) begin
			n = $urandom_range(1, 3);
		end else if (r < 95) begin
			n = $urandom_range(4, 12);
		end else begin
			n = $urandom_range(20, 80);
		end
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue(mode_t m, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
		send_req(m, v, p);
		idle_sender();
	endtask

	// Hold the sender until every answer due has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (mirror.answers_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// One random request, biased to keep the live set small
	task automatic random_item();
		int unsigned n;
		int unsigned r;
		int unsigned k;
		mode_t m;
		logic [VALUE_W-1:0] v;
		logic [POS_W-1:0] p;
		n = mirror.n_elems;
		r = $urandom_range(0, 99);
		if (n > 120) begin
			if (r < 15) m = MODE_ADD;
			else if (r < 60) m = MODE_REMOVE;
			else if (r < 80) m = MODE_FIND;
			else m = MODE_FINDPOS;
		end else begin
			if (r < 40) m = MODE_ADD;
			else if (r < 60) m = MODE_REMOVE;
			else if (r < 80) m = MODE_FIND;
			else m = MODE_FINDPOS;
		end
		// pick members and their neighbors often, to hit duplicates and rank edges
		r = $urandom_range(0, 99);
		if (n == 0 || r < 35) begin
			v = any_value();
		end else begin
			k = $urandom_range(0, n - 1);
			v = mirror.elems[k];
			if (r >= 85) begin
				v = v - 1'b1;
			end else if (r >= 70) begin
				v = v + 1'b1;
			end
		end
		if (n == 0 || $urandom_range(0, 9) < 3) begin
			p = any_position();
		end else begin
			p = POS_W'($urandom_range(0, (n > CAPACITY_DEF - 1) ? CAPACITY_DEF - 1 : n));
		end
		issue(m, v, p);
	endtask

	initial begin
		logic [VALUE_W-1:0] snapshot [FILL_ITEMS];
		logic [VALUE_W-1:0] v;
		int i;

		arst_n          <= 1'b0;
		no_gaps         <= 1'b0;
		stalled_cycles  <= 0;
		req_ch.valid    <= 1'b0;
		req_ch.mode     <= MODE_ADD;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty set, extremes, duplicates, misses, bounds
		issue(MODE_FIND,    any_value(), '0);
		issue(MODE_FINDPOS, '0, any_position());
		issue(MODE_FINDPOS, '1, any_position());
		issue(MODE_ADD,     '1, any_position());
		issue(MODE_ADD,     '0, any_position());
		issue(MODE_ADD,     '0, any_position());
		issue(MODE_REMOVE,  VALUE_W'(5), any_position());
		issue(MODE_ADD,     VALUE_W'(1 << (VALUE_W - 1)), any_position());
		issue(MODE_FIND,    any_value(), POS_W'(0));
		issue(MODE_FIND,    any_value(), POS_W'(1));
		issue(MODE_FIND,    any_value(), POS_W'(2));
		issue(MODE_FIND,    any_value(), POS_W'(3));
		issue(MODE_FIND,    any_value(), '1);
		issue(MODE_FINDPOS, '0, any_position());
		issue(MODE_FINDPOS, VALUE_W'(1), any_position());
		issue(MODE_FINDPOS, VALUE_W'(1 << (VALUE_W - 1)), any_position());
		issue(MODE_FINDPOS, '1, any_position());
		issue(MODE_REMOVE,  VALUE_W'(1 << (VALUE_W - 1)), any_position());
		issue(MODE_REMOVE,  VALUE_W'(1 << (VALUE_W - 1)), any_position());
		issue(MODE_FINDPOS, '1, any_position());
		issue(MODE_REMOVE,  '0, any_position());
		issue(MODE_REMOVE,  '1, any_position());
		issue(MODE_FIND,    any_value(), '0);
		wait_drained();

		// Fill in ascending order, so no entry has to move
		for (i = 0; i < FILL_ITEMS; i++) begin
			issue(MODE_ADD, VALUE_W'(i * 1024 + $urandom_range(0, 1023)), any_position());
			if (i % 32 == 31)
				issue(MODE_FINDPOS, any_value(), any_position());
		end
		wait_drained();

		// Duplicate add, missed remove, rank of an absent value, count bounds
		do
			v = any_value();
		while (mirror.holds(v));
		issue(MODE_ADD,     mirror.elems[FILL_ITEMS / 2], any_position());
		issue(MODE_REMOVE,  v, any_position());
		issue(MODE_FINDPOS, v, any_position());
		issue(MODE_FIND,    any_value(), POS_W'(FILL_ITEMS - 1));
		issue(MODE_FIND,    any_value(), POS_W'(FILL_ITEMS));
		issue(MODE_FINDPOS, '1, any_position());
		issue(MODE_FINDPOS, '0, any_position());
		wait_drained();
		// one full-length shift each way
		v = mirror.elems[0];
		issue(MODE_REMOVE,  v, any_position());
		issue(MODE_FIND,    any_value(), POS_W'(FILL_ITEMS - 1));
		issue(MODE_ADD,     v, any_position());
		issue(MODE_FIND,    any_value(), '0);
		wait_drained();

		// Drain from the top, so no entry has to move
		for (i = 0; i < FILL_ITEMS; i++)
			snapshot[i] = mirror.elems[i];
		for (i = FILL_ITEMS - 1; i >= 0; i--) begin
			issue(MODE_REMOVE, snapshot[i], any_position());
			if (i % 32 == 0) begin
				issue(MODE_FIND,    any_value(), any_position());
				issue(MODE_FINDPOS, any_value(), any_position());
			end
		end
		wait_drained();

		// Random phase, in blocks that sometimes run back to back
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 32 == 0)
				no_gaps <= ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			random_item();
		end

		// Let the last requests finish before judging
		no_gaps <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.answers_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* ordered_set_rank_select_core.f */
src/osrs_pkg.sv
src/osrs_req_if.sv
src/osrs_rsp_if.sv
src/osrs_ram.sv
src/osrs_ctrl.sv
src/ordered_set_rank_select_core.sv
test/ordered_set_rank_select_core_tb.sv
